>>> sv/tpgh_pkg.sv
// Shared widths, register codes, types and the arctangent table of the heading core.
package tpgh_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 32;
  localparam int HEAD_W   = 16;
  localparam int DIFF_W   = 18;   // c-b and b+c-2a
  localparam int PROD_W   = 50;   // 18 x 32 signed product
  localparam int MAG_W    = 58;   // normalised magnitude, top bit at 57
  localparam int CW       = 61;   // CORDIC x/y with gain headroom
  localparam int ZW       = 33;   // accumulated angle, 2^-30 rad
  localparam int AW       = 34;   // final angle before rounding
  localparam int TAB_LEN  = 24;
  localparam int TAB_IDX_W = 5;
  localparam int TAB_W    = 32;

  // Configuration register indices
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHIRALITY = 2'd2;

  localparam logic signed [GAIN_W-1:0] GAIN_X_RST = 32'sd65536;
  localparam logic signed [GAIN_W-1:0] GAIN_Y_RST = 32'sd23853;

  // Angles in 2^-30 rad
  localparam logic signed [AW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd1686629713;

  // Per-beat control that rides along the pipeline
  typedef struct packed {
    logic valid;
    logic nx;      // x operand negative
    logic ny;      // y operand negative
    logic x_zero;
    logic y_zero;
  } tpgh_ctl_t;

  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } tpgh_mag_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
  } tpgh_vec_t;

  // atan(2^-i) in 2^-30 rad
  function automatic logic [TAB_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] i);
    logic [TAB_W-1:0] r;
    case (i)
      5'd0:    r = 32'd843314856;
      5'd1:    r = 32'd497837829;
      5'd2:    r = 32'd263043836;
      5'd3:    r = 32'd133525158;
      5'd4:    r = 32'd67021686;
      5'd5:    r = 32'd33543515;
      5'd6:    r = 32'd16775850;
      5'd7:    r = 32'd8388437;
      5'd8:    r = 32'd4194282;
      5'd9:    r = 32'd2097149;
      5'd10:   r = 32'd1048575;
      5'd11:   r = 32'd524287;
      5'd12:   r = 32'd262143;
      5'd13:   r = 32'd131071;
      5'd14:   r = 32'd65535;
      5'd15:   r = 32'd32767;
      5'd16:   r = 32'd16383;
      5'd17:   r = 32'd8191;
      5'd18:   r = 32'd4095;
      5'd19:   r = 32'd2047;
      5'd20:   r = 32'd1023;
      5'd21:   r = 32'd511;
      5'd22:   r = 32'd255;
      5'd23:   r = 32'd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One step of the leading-zero shift: move both magnitudes up by k
  // when the top k bits of their OR are clear.
  function automatic tpgh_mag_t norm_step(input tpgh_mag_t m, input int unsigned k);
    tpgh_mag_t r;
    r = m;
    if (((m.ax | m.ay) >> (MAG_W - k)) == '0) begin
      r.ax = m.ax << k;
      r.ay = m.ay << k;
    end
    return r;
  endfunction

endpackage

>>> sv/tpgh_if.sv
// Stream and configuration interfaces of the heading core.
interface tpgh_sensor_if import tpgh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_front;
  logic signed [SAMPLE_W-1:0] sample_plus;
  logic signed [SAMPLE_W-1:0] sample_minus;

  modport source (output valid, sample_front, sample_plus, sample_minus, input ready);
  modport sink   (input valid, sample_front, sample_plus, sample_minus, output ready);
endinterface

interface tpgh_heading_if import tpgh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] heading;

  modport source (output valid, heading, input ready);
  modport sink   (input valid, heading, output ready);
endinterface

interface tpgh_cfg_if import tpgh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/tpgh_front.sv
// Front end: sensor differences, gain products, sign split and magnitudes.
module tpgh_front import tpgh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic signed [SAMPLE_W-1:0] sample_front,
  input  logic signed [SAMPLE_W-1:0] sample_plus,
  input  logic signed [SAMPLE_W-1:0] sample_minus,
  input  logic signed [GAIN_W-1:0]   gain_x,
  input  logic signed [GAIN_W-1:0]   gain_y,
  input  logic                       chirality_cw,
  output tpgh_ctl_t                  ctl,
  output tpgh_mag_t                  mag
);

  logic signed [DIFF_W-1:0] dx, dy;
  logic                     v1, v2;
  logic signed [DIFF_W-1:0] xd, yd;
  logic signed [GAIN_W-1:0] xg, yg;
  logic signed [PROD_W-1:0] px, py;
  logic [PROD_W-1:0]        abs_x, abs_y;

  // dx = (C-A)-(B-A), dy = (C-A)+(B-A)
  always_comb begin
    dx = DIFF_W'(sample_minus) - DIFF_W'(sample_plus);
    dy = DIFF_W'(sample_minus) + DIFF_W'(sample_plus) - (DIFF_W'(sample_front) <<< 1);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // stage 1: operand routing by chirality (x and y of the atan2)
  always_ff @(posedge clk) begin
    if (adv) begin
      if (chirality_cw) begin
        xd <= dx;
        xg <= gain_x;
        yd <= dy;
        yg <= gain_y;
      end else begin
        xd <= dy;
        xg <= gain_y;
        yd <= dx;
        yg <= gain_x;
      end
    end
  end

  // stage 2: gain products
  always_ff @(posedge clk) begin
    if (adv) begin
      px <= xd * xg;
      py <= yd * yg;
    end
  end

  // stage 3: signs, zero flags and magnitudes
  always_comb begin
    abs_x = px[PROD_W-1] ? unsigned'(-px) : unsigned'(px);
    abs_y = py[PROD_W-1] ? unsigned'(-py) : unsigned'(py);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.valid  <= v2;
      ctl.nx     <= px[PROD_W-1];
      ctl.ny     <= py[PROD_W-1];
      ctl.x_zero <= (px == '0);
      ctl.y_zero <= (py == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag.ax <= {{(MAG_W-PROD_W){1'b0}}, abs_x};
      mag.ay <= {{(MAG_W-PROD_W){1'b0}}, abs_y};
    end
  end

endmodule

>>> sv/tpgh_norm.sv
// Three-stage leading-zero normalisation of the magnitude pair.
module tpgh_norm import tpgh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  tpgh_ctl_t ctl_in,
  input  tpgh_mag_t mag_in,
  output tpgh_ctl_t ctl_out,
  output tpgh_vec_t vec_out
);

  tpgh_ctl_t ctl1, ctl2;
  tpgh_mag_t m1, m2, m3_next;

  // control beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  assign m3_next = norm_step(norm_step(m2, 2), 1);

  // shifts by 32/16, then 8/4, then 2/1
  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= norm_step(norm_step(mag_in, 32), 16);
      m2 <= norm_step(norm_step(m1, 8), 4);
      vec_out.cx <= signed'({{(CW-MAG_W){1'b0}}, m3_next.ax});
      vec_out.cy <= signed'({{(CW-MAG_W){1'b0}}, m3_next.ay});
      vec_out.z  <= '0;
    end
  end

endmodule

>>> sv/tpgh_cordic_stage.sv
// One vectoring CORDIC iteration with its pipeline register.
module tpgh_cordic_stage import tpgh_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  tpgh_ctl_t ctl_in,
  input  tpgh_vec_t vec_in,
  output tpgh_ctl_t ctl_out,
  output tpgh_vec_t vec_out
);

  logic signed [CW-1:0] cx, cy, sx, sy;
  logic signed [ZW-1:0] z, da;

  // rotate towards the x axis
  always_comb begin
    cx = vec_in.cx;
    cy = vec_in.cy;
    z  = vec_in.z;
    sx = cx >>> STEP;
    sy = cy >>> STEP;
    da = signed'({1'b0, atan_tab(TAB_IDX_W'(STEP))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cy > 0) begin
        vec_out.cx <= cx + sy;
        vec_out.cy <= cy - sx;
        vec_out.z  <= z + da;
      end else begin
        vec_out.cx <= cx - sy;
        vec_out.cy <= cy + sx;
        vec_out.z  <= z - da;
      end
    end
  end

endmodule

>>> sv/tpgh_out.sv
// Quadrant fix-up, rounding to Q2.13, output register and skid buffer.
module tpgh_out import tpgh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  tpgh_ctl_t                ctl_in,
  input  logic signed [ZW-1:0]     z_in,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [HEAD_W-1:0] heading,
  output logic                     adv
);

  localparam logic signed [17:0] H_PI = 18'sd25736;

  logic signed [AW-1:0]     z_ext, t, ang_next, ang;
  logic                     ang_valid;
  logic signed [AW:0]       sum;
  logic signed [17:0]       h;
  logic signed [HEAD_W-1:0] h_out;
  logic                     skid_valid;
  logic signed [HEAD_W-1:0] skid_data;

  assign adv = !skid_valid;

  // quadrant and axis cases
  always_comb begin
    z_ext = AW'(z_in);
    t = ctl_in.nx ? ANG_PI - z_ext : z_ext;
    ang_next = ctl_in.ny ? -t : t;
    if (ctl_in.y_zero) begin
      ang_next = ctl_in.nx ? ANG_PI : '0;
    end else if (ctl_in.x_zero) begin
      ang_next = ctl_in.ny ? -ANG_HALF_PI : ANG_HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else if (adv) begin
      ang_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang <= ang_next;
    end
  end

  // negate, round to Q2.13, fold -pi onto +pi
  always_comb begin
    sum   = -((AW+1)'(ang)) + 35'sd65536;
    h     = signed'(sum[AW:17]);
    h_out = (h <= -H_PI || h > H_PI) ? HEAD_W'(H_PI) : h[HEAD_W-1:0];
  end

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= ang_valid;
    end else if (ang_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        heading <= skid_data;
      end
    end else if (!out_valid || out_ready) begin
      heading <= h_out;
    end else begin
      skid_data <= h_out;
    end
  end

  // a parked beat always sits behind a shown one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  // a parked beat is not dropped while the output stalls
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid_data))
    else $error("skid beat lost during stall");

  // heading stays in (-pi, pi]
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading >= -16'sd25735) && (heading <= 16'sd25736))
    else $error("heading out of range");

endmodule

>>> sv/three_point_gradient_heading_core.sv
// Top level: three-sample gradient heading with an unrolled CORDIC pipeline.
//
//  channel   modport  beat contents
//  sensors   sink     sample_front, sample_plus, sample_minus (s16 each)
//  result    source   heading (s16, Q2.13 rad, (-pi, pi])
//  cfg       sink     index (0 gain_x, 1 gain_y, 2 chirality_cw), data (32 bit)
//
//  One beat per cycle while the skid register is empty; the chain holds one CORDIC
//  iteration per stage plus 3 front, 3 normalise and 2 output stages.
//  rst (synchronous) clears all valid bits and loads the register defaults.
//  The whole pipeline holds only while the skid register is full; sensors.ready
//  comes from that register alone. cfg.ready is always high.
module three_point_gradient_heading_core import tpgh_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input logic         clk,
  input logic         rst,
  tpgh_sensor_if.sink sensors,
  tpgh_cfg_if.sink    cfg,
  tpgh_heading_if.source result
);

  localparam int N_ITER = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  logic signed [GAIN_W-1:0] gain_x, gain_y;
  logic                     chirality_cw;
  logic                     adv;
  tpgh_ctl_t                f_ctl;
  tpgh_mag_t                f_mag;
  tpgh_ctl_t                ctl [0:N_ITER];
  tpgh_vec_t                vec [0:N_ITER];

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x       <= GAIN_X_RST;
      gain_y       <= GAIN_Y_RST;
      chirality_cw <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN_X:    gain_x <= signed'(cfg.data);
        REG_GAIN_Y:    gain_y <= signed'(cfg.data);
        REG_CHIRALITY: chirality_cw <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign sensors.ready = adv;

  tpgh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (sensors.valid),
    .sample_front (sensors.sample_front),
    .sample_plus  (sensors.sample_plus),
    .sample_minus (sensors.sample_minus),
    .gain_x       (gain_x),
    .gain_y       (gain_y),
    .chirality_cw (chirality_cw),
    .ctl          (f_ctl),
    .mag          (f_mag)
  );

  tpgh_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (f_ctl),
    .mag_in  (f_mag),
    .ctl_out (ctl[0]),
    .vec_out (vec[0])
  );

  // CORDIC chain, one iteration per stage
  for (genvar i = 0; i < N_ITER; i++) begin : g_cordic
    tpgh_cordic_stage #(.STEP(i)) u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_in  (ctl[i]),
      .vec_in  (vec[i]),
      .ctl_out (ctl[i+1]),
      .vec_out (vec[i+1])
    );
  end

  tpgh_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl[N_ITER]),
    .z_in      (vec[N_ITER].z),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .heading   (result.heading),
    .adv       (adv)
  );

endmodule

>>> sim/testbench.sv
// Self-checking testbench of the three-point gradient heading core.
`timescale 1ns / 100ps

module testbench;
  import tpgh_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int PIPE_LATENCY = CORDIC_STEPS + 8;
  localparam int IDLE_PCT     = 29;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 225;
  localparam int N_PHASES     = 8;
  localparam int HOLD_PHASE   = 2;
  localparam int STEADY_PHASE = 5;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int DIR_ROWS     = 24;
  localparam int ATAN_LEN     = 24;

  // Index past the end of the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Angles in 2^-30 rad, heading in Q2.13
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint HEAD_PI     = 64'sd25736;

  localparam longint ATAN_Q30 [ATAN_LEN] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047,
    1023, 511, 255, 127
  };

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [HEAD_W-1:0]   heading_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;

  // One directed row: register setting, samples, and optionally a typed-in heading
  typedef struct packed {
    gain_t    gx;
    gain_t    gy;
    logic     cw;
    sample_t  a;
    sample_t  b;
    sample_t  c;
    logic     typed;
    heading_t want;
  } dir_row_t;

  localparam gain_t GX_DEF = 32'sd65536;
  localparam gain_t GY_DEF = 32'sd23853;
  localparam gain_t G_MAX  = 32'sh7fffffff;
  localparam gain_t G_MIN  = 32'sh80000000;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset setting: zero gradient, axis angles, minus pi folding, sample extremes
    '{GX_DEF, GY_DEF, 1'b0,      16'sd0,      16'sd0,      16'sd0, 1'b1,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b0,   16'sd1234,   16'sd1234,   16'sd1234, 1'b1,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b0,      16'sd0,    16'sd100,    16'sd100, 1'b1,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b0,    16'sd100,      16'sd0,      16'sd0, 1'b1,  16'sd25736},
    '{GX_DEF, GY_DEF, 1'b0,      16'sd0,   -16'sd100,    16'sd100, 1'b1, -16'sd12868},
    '{GX_DEF, GY_DEF, 1'b0,      16'sd0,    16'sd100,   -16'sd100, 1'b1,  16'sd12868},
    '{GX_DEF, GY_DEF, 1'b0, 16'sh8000,   16'sh7fff,   16'sh7fff, 1'b1,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b0, 16'sh7fff,   16'sh8000,   16'sh8000, 1'b1,  16'sd25736},
    '{GX_DEF, GY_DEF, 1'b0, 16'sh7fff,   16'sh8000,   16'sh7fff, 1'b0,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b0, 16'sh8000,   16'sh7fff,   16'sh8000, 1'b0,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b0,      16'sd0,     16'sd10,     16'sd30, 1'b0,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b0,     -16'sd1,     -16'sd1,      16'sd0, 1'b0,      16'sd0},
    // clockwise: angle on each axis
    '{GX_DEF, GY_DEF, 1'b1,      16'sd0,   -16'sd100,    16'sd100, 1'b1,      16'sd0},
    '{GX_DEF, GY_DEF, 1'b1,      16'sd0,    16'sd100,   -16'sd100, 1'b1,  16'sd25736},
    '{GX_DEF, GY_DEF, 1'b1,      16'sd0,    16'sd100,    16'sd100, 1'b1, -16'sd12868},
    '{GX_DEF, GY_DEF, 1'b1,      16'sd5,    16'sd900,     16'sd17, 1'b0,      16'sd0},
    // degenerate geometry: one or both gains zero
    '{32'sd0, GY_DEF, 1'b0,      16'sd3, -16'sd20000,  16'sd31000, 1'b1,      16'sd0},
    '{GX_DEF, 32'sd0, 1'b0,      16'sd0,      16'sd5,   16'sd1000, 1'b1, -16'sd12868},
    '{32'sd0, 32'sd0, 1'b1,      16'sd7,    16'sd300,  -16'sd4000, 1'b1,      16'sd0},
    // gain extremes
    '{G_MIN,  G_MAX,  1'b0, 16'sh7fff,   16'sh8000,   16'sh7fff, 1'b0,      16'sd0},
    '{G_MIN,  G_MAX,  1'b0, 16'sh8000,   16'sh7fff,   16'sh8000, 1'b0,      16'sd0},
    '{G_MIN,  G_MAX,  1'b0,    16'sd100,    16'sd101,     16'sd99, 1'b0,      16'sd0},
    '{G_MAX,  G_MIN,  1'b1, 16'sh8000,   16'sh7fff,   16'sh7fff, 1'b1,  16'sd12868},
    '{G_MAX,  G_MIN,  1'b1,      16'sd1,      16'sd2,      16'sd4, 1'b0,      16'sd0}
  };

  logic clk;
  logic rst;

  tpgh_sensor_if  sensor_bus ();
  tpgh_cfg_if     cfg_bus ();
  tpgh_heading_if heading_bus ();

  three_point_gradient_heading_core #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .sensors(sensor_bus),
    .cfg    (cfg_bus),
    .result (heading_bus)
  );

  // Register copy kept alongside the core
  gain_t gain_x_cur;
  gain_t gain_y_cur;
  logic  cw_cur;

  heading_t heading_due_q [$];

  int   fail_cnt     = 0;
  int   checked_cnt  = 0;
  int   sent_cnt     = 0;
  int   setting_cnt  = 0;
  int   hold_req_cnt = 0;
  logic rx_steady    = 1'b0;
  logic tx_steady    = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("testbench: FAIL");
    $finish;
  end

  // Vectoring CORDIC atan2(y, x) in 2^-30 rad, exact on the axes
  function automatic longint vector_atan2(input longint y, input longint x);
    logic   ny, nx;
    longint ay, ax, mx, cx, cy, z, t, nxt;
    ny = (y < 0);
    nx = (x < 0);
    ay = ny ? -y : y;
    ax = nx ? -x : x;
    if (ay == 0) return nx ? PI_Q30 : 64'sd0;
    if (ax == 0) return ny ? -HALF_PI_Q30 : HALF_PI_Q30;
    // normalise so the larger magnitude has its top bit at 57
    mx = (ax > ay) ? ax : ay;
    while (mx < (longint'(1) <<< 57)) begin
      mx = mx <<< 1;
      ax = ax <<< 1;
      ay = ay <<< 1;
    end
    cx = ax;
    cy = ay;
    z  = 0;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      if (cy > 0) begin
        nxt = cx + (cy >>> i);
        cy  = cy - (cx >>> i);
        z   = z + ATAN_Q30[i];
      end else begin
        nxt = cx - (cy >>> i);
        cy  = cy + (cx >>> i);
        z   = z - ATAN_Q30[i];
      end
      cx = nxt;
    end
    t = nx ? (PI_Q30 - z) : z;
    return ny ? -t : t;
  endfunction

  // Heading of one sensor triple under the current registers
  function automatic heading_t predict_heading(input sample_t a, input sample_t b,
                                               input sample_t c);
    longint gx, gy, ang, h;
    gx  = (longint'(c) - longint'(b)) * longint'(gain_x_cur);
    gy  = (longint'(b) + longint'(c) - 2 * longint'(a)) * longint'(gain_y_cur);
    ang = cw_cur ? vector_atan2(gy, gx) : vector_atan2(gx, gy);
    // negate, round to Q2.13, fold minus pi onto plus pi
    h = (longint'(65536) - ang) >>> 17;
    if (h <= -HEAD_PI) h = HEAD_PI;
    if (h > HEAD_PI) h = HEAD_PI;
    return heading_t'(h);
  endfunction

  // One beat on the configuration channel; valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_GAIN_X:    gain_x_cur = value;
      REG_GAIN_Y:    gain_y_cur = value;
      REG_CHIRALITY: cw_cur = value[0];
      default: ;
    endcase
  endtask

  // Full register setting; chirality and spare writes carry junk in unused bits
  task automatic program_setting(input gain_t gx, input gain_t gy, input logic cw);
    logic [GAIN_W-1:0] junk;
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    junk    = $urandom;
    junk[0] = cw;
    write_reg(REG_CHIRALITY, junk);
    write_reg(REG_SPARE, $urandom);
    cfg_bus.valid <= 1'b0;
    setting_cnt++;
  endtask

  // Stop offering, let every heading come home, then wait out the pipeline
  task automatic drain_headings();
    sensor_bus.valid <= 1'b0;
    while (heading_due_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Offer one triple, after a random gap unless the sender is steady; valid stays high on return
  task automatic send_triple(input sample_t a, input sample_t b, input sample_t c,
                             input logic typed, input heading_t want);
    while (!tx_steady && ($urandom_range(99) < IDLE_PCT)) begin
      sensor_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sensor_bus.valid        <= 1'b1;
    sensor_bus.sample_front <= a;
    sensor_bus.sample_plus  <= b;
    sensor_bus.sample_minus <= c;
    @(posedge clk);
    while (!sensor_bus.ready) @(posedge clk);
    heading_due_q.push_back(typed ? want : predict_heading(a, b, c));
    sent_cnt++;
  endtask

  // Random triple: readings near a common level, random values, corners, one zero gradient term or all equal
  task automatic pick_triple(output sample_t a, output sample_t b, output sample_t c);
    int          base, span;
    logic [31:0] s;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        span = 1 << $urandom_range(14);
        base = int'($urandom_range(65535)) - 32768;
        a = sample_t'(base + int'($urandom_range(2 * span)) - span);
        b = sample_t'(base + int'($urandom_range(2 * span)) - span);
        c = sample_t'(base + int'($urandom_range(2 * span)) - span);
      end
      4, 5, 6: begin
        a = sample_t'($urandom);
        b = sample_t'($urandom);
        c = sample_t'($urandom);
      end
      7: begin
        // corners: 0, -1, max, min
        s = $urandom;
        a = {s[0], {15{s[1]}}};
        b = {s[2], {15{s[3]}}};
        c = {s[4], {15{s[5]}}};
      end
      8: begin
        // one gradient term zero
        a = sample_t'($urandom);
        b = sample_t'($urandom);
        if ($urandom_range(1)) c = b;
        else c = sample_t'(2 * int'(a) - int'(b));
      end
      default: begin
        a = sample_t'($urandom);
        b = a;
        c = a;
      end
    endcase
  endtask

  function automatic gain_t pick_gain();
    case ($urandom_range(2))
      0:       return gain_t'($urandom);
      1:       return gain_t'(int'($urandom_range(262144)) - 131072);
      default: return gain_t'(int'($urandom_range(32'h3fffffff)) - 32'sh20000000);
    endcase
  endfunction

  // Result sink: random stalls, a steady stretch, and one long hold-off on request
  initial begin : sink_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    heading_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        heading_bus.ready <= 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        heading_bus.ready <= 1'b1;
      end else begin
        heading_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each heading beat with the oldest one due
  always @(posedge clk) begin : heading_check
    heading_t want;
    if (!rst && heading_bus.valid && heading_bus.ready) begin
      if (heading_due_q.size() == 0) begin
        $error("heading: unexpected beat, actual %0d", heading_bus.heading);
        fail_cnt++;
      end else begin
        want = heading_due_q.pop_front();
        checked_cnt++;
        if (heading_bus.heading !== want) begin
          $error("heading: expected %0d, actual %0d", want, heading_bus.heading);
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    sample_t a, b, c;
    gain_t   gx, gy;
    logic    cw;

    rst                     <= 1'b1;
    sensor_bus.valid        <= 1'b0;
    sensor_bus.sample_front <= '0;
    sensor_bus.sample_plus  <= '0;
    sensor_bus.sample_minus <= '0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.index           <= '0;
    cfg_bus.data            <= '0;
    gain_x_cur = GX_DEF;
    gain_y_cur = GY_DEF;
    cw_cur     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; the first ones run on the reset values
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].gx != gain_x_cur || dir_tab[i].gy != gain_y_cur ||
          dir_tab[i].cw != cw_cur) begin
        drain_headings();
        program_setting(dir_tab[i].gx, dir_tab[i].gy, dir_tab[i].cw);
      end
      send_triple(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, dir_tab[i].typed,
                  dir_tab[i].want);
    end

    // Random phases, one register setting each
    for (int p = 0; p < N_PHASES; p++) begin
      cw = 1'($urandom_range(1));
      case (p)
        0:       begin gx = GX_DEF;      gy = GY_DEF;      cw = 1'b0; end
        1:       begin gx = GX_DEF;      gy = GY_DEF;      cw = 1'b1; end
        2:       begin gx = G_MAX;       gy = G_MAX;       cw = 1'b0; end
        3:       begin gx = G_MIN;       gy = G_MIN;       cw = 1'b1; end
        4:       begin gx = '0;          gy = pick_gain();            end
        5:       begin gx = pick_gain(); gy = '0;                     end
        6:       begin gx = pick_gain(); gy = pick_gain(); cw = 1'b0; end
        default: begin gx = pick_gain(); gy = pick_gain(); cw = 1'b1; end
      endcase
      drain_headings();
      program_setting(gx, gy, cw);
      tx_steady = (p == STEADY_PHASE);
      rx_steady <= (p == STEADY_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back up the pipeline while the sender keeps offering
        if (p == HOLD_PHASE && n == 40) hold_req_cnt <= hold_req_cnt + 1;
        pick_triple(a, b, c);
        send_triple(a, b, c, 1'b0, '0);
      end
    end

    drain_headings();
    $display("summary: %0d sensor beats over %0d register settings, %0d headings checked",
             sent_cnt, setting_cnt, checked_cnt);
    $display("summary: gain extremes, zero gains, both chiralities, stalls and a long hold-off");
    if (fail_cnt == 0 && heading_due_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tpgh_pkg.sv
sv/tpgh_if.sv
sv/tpgh_front.sv
sv/tpgh_norm.sv
sv/tpgh_cordic_stage.sv
sv/tpgh_out.sv
sv/three_point_gradient_heading_core.sv
sim/testbench.sv
